// ===== rtl/wcdb_pkg.sv =====
`default_nettype none

package wcdb_pkg;

	// Cell table geometry.
	localparam int MAX_CELLS = 1024;
	localparam int ADDR_W = $clog2(MAX_CELLS);
	localparam int CELL_W = 11;

	// Fixed point and divider geometry.
	localparam int FRAC_SHIFT = 30;
	localparam int DIV_STAGES = 32;
	localparam int NUM_FACES = 6;
	localparam int DIV_W = 66;

	localparam logic [31:0] HUGE_DIST = 32'hFFFF_FFFF;
	localparam logic [30:0] TAN_RESET = 31'd1073741824;

	// Operation codes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Per-face outcome while the quotient is being formed.
	typedef enum logic [1:0] {
		FC_HUGE = 2'd0,
		FC_ZERO = 2'd1,
		FC_DIV = 2'd2
	} face_code_t;

endpackage

`default_nettype wire

// ===== rtl/wedge_cell_distance_to_boundary.sv =====
`default_nettype none

// Distance to the boundary of a wedge mesh cell.
// The input channel (in_valid/in_ready) carries one word per item. A load word
// (operation 0) writes the x and z extents of a cell into the extent memories
// and yields no result. A query word (operation 1) reads the cell's extents and
// yields one result word on the output channel (out_valid/out_ready): the
// smallest distance along the ray in Q16.16 and the face it hits.
// The configuration channel (cfg_valid/cfg_ready) writes tan_half_angle; it is
// always ready, and the user must write it only while the block is idle; the
// block itself leaves this unchecked. A query result passes through registered
// stages in order: memory read and multiply, numerators and denominators, face
// tests and divider operands, the six pipelined dividers (one quotient bit per
// stage) and the final minimum that writes the two-word output queue.
// Throughput: one word per cycle, loads and queries mixed freely, while the
// output queue has room. When the receiver stalls, results collect in it;
// once it is full the whole pipeline holds and in_ready drops.
// Reset empties the pipeline and the queue and sets tan_half_angle to 1.0;
// the extent memories are not cleared, so a cell must be loaded before use.
module wedge_cell_distance_to_boundary
	import wcdb_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic operation,
	input wire logic [CELL_W-1:0] cell_number,
	input wire logic signed [31:0] load_low_x,
	input wire logic signed [31:0] load_high_x,
	input wire logic signed [31:0] load_low_z,
	input wire logic signed [31:0] load_high_z,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [31:0] pos_z,
	input wire logic signed [31:0] dir_x,
	input wire logic signed [31:0] dir_y,
	input wire logic signed [31:0] dir_z,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] distance,
	output logic [2:0] face_number,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [30:0] tan_half_angle
);

	// Configuration register.
	logic [30:0] tan_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_q <= TAN_RESET;
		end else if (cfg_valid) begin
			tan_q <= tan_half_angle;
		end
	end

	// Pipeline enable: everything moves while the output queue has room.
	logic [1:0] cnt_q;
	logic en;
	logic acc;
	logic cell_ok;
	logic [ADDR_W-1:0] addr;

	assign en = (cnt_q != 2'd2);
	assign in_ready = en;
	assign acc = in_valid && en;
	assign cell_ok = (cell_number != '0) && (cell_number <= CELL_W'(MAX_CELLS));
	assign addr = ADDR_W'(cell_number - CELL_W'(1));

	// Extent memories with registered read data.
	logic [63:0] rad_mem [MAX_CELLS];
	logic [63:0] ax_mem [MAX_CELLS];
	logic [63:0] rad_s1;
	logic [63:0] ax_s1;

	always_ff @(posedge clk) begin
		if (acc && cell_ok) begin
			if (operation == OP_LOAD) begin
				rad_mem[addr] <= {load_high_x, load_low_x};
				ax_mem[addr] <= {load_high_z, load_low_z};
			end else begin
				rad_s1 <= rad_mem[addr];
				ax_s1 <= ax_mem[addr];
			end
		end
	end

	// Stage 1: query fields and the two wedge products.
	logic v_s1;
	logic ok_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1, dx_s1, dy_s1, dz_s1;
	logic signed [63:0] pxt_s1, dxt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc && (operation == OP_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s1 <= cell_ok;
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			pz_s1 <= pos_z;
			dx_s1 <= dir_x;
			dy_s1 <= dir_y;
			dz_s1 <= dir_z;
			pxt_s1 <= pos_x * $signed({1'b0, tan_q});
			dxt_s1 <= dir_x * $signed({1'b0, tan_q});
		end
	end

	// Stage 2: signed numerators and denominators of all six faces.
	logic v_s2;
	logic signed [32:0] nlx_s2, nhx_s2, nlz_s2, nhz_s2;
	logic signed [31:0] dx_s2, dz_s2;
	logic signed [63:0] sy_s2, w4_s2, den3_s2, den4_s2;
	logic [63:0] rad_c, ax_c;
	logic signed [63:0] py_sh, dy_sh;

	assign rad_c = ok_s1 ? rad_s1 : '0;
	assign ax_c = ok_s1 ? ax_s1 : '0;
	assign py_sh = {{2{py_s1[31]}}, py_s1, {FRAC_SHIFT{1'b0}}};
	assign dy_sh = {{2{dy_s1[31]}}, dy_s1, {FRAC_SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nlx_s2 <= $signed({rad_c[31], rad_c[31:0]}) - $signed({px_s1[31], px_s1});
			nhx_s2 <= $signed({rad_c[63], rad_c[63:32]}) - $signed({px_s1[31], px_s1});
			nlz_s2 <= $signed({ax_c[31], ax_c[31:0]}) - $signed({pz_s1[31], pz_s1});
			nhz_s2 <= $signed({ax_c[63], ax_c[63:32]}) - $signed({pz_s1[31], pz_s1});
			dx_s2 <= dx_s1;
			dz_s2 <= dz_s1;
			sy_s2 <= py_sh + pxt_s1;
			w4_s2 <= pxt_s1 - py_sh;
			den3_s2 <= dy_sh + dxt_s1;
			den4_s2 <= dxt_s1 - dy_sh;
		end
	end

	// Stage 3: face tests, outcome codes and magnitudes for the dividers.
	logic v_s3;
	face_code_t code_s3 [NUM_FACES];
	logic [63:0] n_s3 [NUM_FACES];
	logic [63:0] d_s3 [NUM_FACES];
	logic signed [63:0] dx_w, dz_w;

	assign dx_w = 64'(dx_s2);
	assign dz_w = 64'(dz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s3[0] <= (dx_s2 >= 0) ? FC_HUGE : ((nlx_s2 < 0) ? FC_DIV : FC_ZERO);
			n_s3[0] <= 64'(-nlx_s2);
			d_s3[0] <= -dx_w;
			code_s3[1] <= (dx_s2 <= 0) ? FC_HUGE : ((nhx_s2 > 0) ? FC_DIV : FC_ZERO);
			n_s3[1] <= 64'(nhx_s2);
			d_s3[1] <= dx_w;
			code_s3[2] <= (den3_s2 >= 0) ? FC_HUGE : ((sy_s2 > 0) ? FC_DIV : FC_ZERO);
			n_s3[2] <= sy_s2;
			d_s3[2] <= -den3_s2;
			code_s3[3] <= (den4_s2 >= 0) ? FC_HUGE : ((w4_s2 > 0) ? FC_DIV : FC_ZERO);
			n_s3[3] <= w4_s2;
			d_s3[3] <= -den4_s2;
			code_s3[4] <= (dz_s2 >= 0) ? FC_HUGE : ((nlz_s2 < 0) ? FC_DIV : FC_ZERO);
			n_s3[4] <= 64'(-nlz_s2);
			d_s3[4] <= -dz_w;
			code_s3[5] <= (dz_s2 <= 0) ? FC_HUGE : ((nhz_s2 > 0) ? FC_DIV : FC_ZERO);
			n_s3[5] <= 64'(nhz_s2);
			d_s3[5] <= dz_w;
		end
	end

	// Six dividers running side by side.
	logic [31:0] q_c [NUM_FACES];
	logic sat_c [NUM_FACES];

	genvar f;
	generate
		for (f = 0; f < NUM_FACES; f++) begin : g_face
			wcdb_div u_div (
				.clk(clk),
				.en(en),
				.n(n_s3[f]),
				.d(d_s3[f]),
				.q(q_c[f]),
				.sat(sat_c[f])
			);
		end
	endgenerate

	// Valid bits and face codes travel beside the dividers.
	logic vld_q [DIV_STAGES];
	face_code_t code_q [DIV_STAGES][NUM_FACES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= v_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_q[0] <= code_s3;
			for (int i = 1; i < DIV_STAGES; i++) begin
				code_q[i] <= code_q[i-1];
			end
		end
	end

	// Minimum over the faces; strict compare keeps the lower face on ties.
	logic [31:0] best_c;
	logic [2:0] face_c;

	always_comb begin
		logic [31:0] dist_f;
		best_c = HUGE_DIST;
		face_c = 3'd1;
		for (int i = 0; i < NUM_FACES; i++) begin
			unique case (code_q[DIV_STAGES-1][i])
				FC_DIV: dist_f = sat_c[i] ? HUGE_DIST : q_c[i];
				FC_ZERO: dist_f = '0;
				default: dist_f = HUGE_DIST;
			endcase
			if (dist_f < best_c) begin
				best_c = dist_f;
				face_c = 3'(i + 1);
			end
		end
	end

	// Two-word output queue.
	logic [31:0] buf_dist_q [2];
	logic [2:0] buf_face_q [2];
	logic head_q;
	logic push;
	logic pop;
	logic wr_idx;

	assign push = en && vld_q[DIV_STAGES-1];
	assign pop = out_valid && out_ready;
	assign wr_idx = head_q ^ cnt_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			head_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (pop) begin
				head_q <= ~head_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_dist_q[wr_idx] <= best_c;
			buf_face_q[wr_idx] <= face_c;
		end
	end

	assign out_valid = (cnt_q != '0);
	assign distance = buf_dist_q[head_q];
	assign face_number = buf_face_q[head_q];

`ifndef SYNTHESIS
	// The queue never holds more than two words.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output queue overflow");

	// A full queue holds off new input.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> !in_ready) else $error("input taken with full queue");

	// A delivered face is one of the six.
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (face_number != 3'd0 && face_number != 3'd7))
		else $error("face number out of range");

	// A huge distance always reports the first face.
	a_huge_face: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && distance == HUGE_DIST) |-> face_number == 3'd1)
		else $error("huge distance with a face other than the first");
`endif

endmodule

`default_nettype wire

// ===== rtl/wcdb_div.sv =====
`default_nettype none

// Pipelined restoring divider: q = floor(n * 2^30 / d), with a flag when the
// quotient needs more than 32 bits. One quotient bit per stage.
module wcdb_div
	import wcdb_pkg::*;
(
	input wire logic clk,
	input wire logic en,
	input wire logic [63:0] n,
	input wire logic [63:0] d,
	output logic [31:0] q,
	output logic sat
);

	logic [DIV_W-1:0] rem_q [DIV_STAGES-1];
	logic [63:0] den_q [DIV_STAGES-1];
	logic [31:0] quo_q [DIV_STAGES];
	logic sat_q [DIV_STAGES];

	genvar j;
	generate
		for (j = 0; j < DIV_STAGES; j++) begin : g_stage
			logic [DIV_W-1:0] a_c;
			logic [DIV_W-1:0] b_c;
			logic bit_c;
			logic [31:0] qin_c;
			logic sin_c;

			// Select the partial remainder and the divisor step for this bit.
			if (j == 0) begin : g_first
				always_comb begin
					a_c = {2'b00, n};
					b_c = {1'b0, d, 1'b0};
					qin_c = '0;
					sin_c = ({2'b00, n} >= {d, 2'b00});
				end
			end else if (j == 1) begin : g_second
				always_comb begin
					a_c = rem_q[0];
					b_c = {2'b00, den_q[0]};
					qin_c = quo_q[0];
					sin_c = sat_q[0];
				end
			end else begin : g_rest
				always_comb begin
					a_c = {rem_q[j-1][DIV_W-2:0], 1'b0};
					b_c = {2'b00, den_q[j-1]};
					qin_c = quo_q[j-1];
					sin_c = sat_q[j-1];
				end
			end

			assign bit_c = (a_c >= b_c);

			// Quotient and flag advance in every stage.
			always_ff @(posedge clk) begin
				if (en) begin
					quo_q[j] <= {qin_c[30:0], bit_c};
					sat_q[j] <= sin_c;
				end
			end

			// Remainder and divisor are only needed by the stages that follow.
			if (j < DIV_STAGES - 1) begin : g_carry
				always_ff @(posedge clk) begin
					if (en) begin
						rem_q[j] <= bit_c ? (a_c - b_c) : a_c;
					end
				end

				if (j == 0) begin : g_den_first
					always_ff @(posedge clk) begin
						if (en) begin
							den_q[j] <= d;
						end
					end
				end else begin : g_den_rest
					always_ff @(posedge clk) begin
						if (en) begin
							den_q[j] <= den_q[j-1];
						end
					end
				end
			end
		end
	endgenerate

	assign q = quo_q[DIV_STAGES-1];
	assign sat = sat_q[DIV_STAGES-1];

endmodule

`default_nettype wire
